@@ sv/udpcsum_pkg.sv @@
package udpcsum_pkg;

    // result queue between the pipeline and the output port
    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);

    // binary accumulator, wide enough for a full 64 KiB datagram plus pseudo header
    localparam int unsigned SumW = 32;

    localparam logic [15:0] ProtoUdp   = 16'h0011;
    localparam logic [15:0] SumAllOnes = 16'hFFFF;
    localparam logic [15:0] OffsetMax  = 16'hFFFF;

    // byte offsets of the udp header fields
    localparam logic [15:0] OffSrcHi = 16'd0;
    localparam logic [15:0] OffSrcLo = 16'd1;
    localparam logic [15:0] OffDstHi = 16'd2;
    localparam logic [15:0] OffDstLo = 16'd3;
    localparam logic [15:0] OffLenHi = 16'd4;
    localparam logic [15:0] OffLenLo = 16'd5;

    // first byte summed on arrival, first payload byte, shortest reported datagram end
    localparam logic [15:0] OffSumStart = 16'd6;
    localparam logic [15:0] OffPayStart = 16'd8;
    localparam logic [15:0] OffRepMin   = 16'd7;

    // result kind codes
    localparam logic KindPayload = 1'b0;
    localparam logic KindReport  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_offset;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] datagram_length;
        logic        checksum_ok;
        logic        final_res;
    } t_result;

endpackage

@@ sv/udp_header_checksum_checker.sv @@
// UDP header and checksum checker. Takes one byte of an IPv4 payload per transfer
// (first marks the datagram start and samples the IP addresses), passes payload
// bytes from offset 8 up to the UDP length field through as kind 0 results, and on
// the last byte of a datagram of 8 or more bytes issues a kind 1 report with the
// ports, the length and the pseudo-header checksum verdict. A byte that is both a
// payload byte and the last one gives the payload result first, then the report.
// Throughput is one byte per clock unless stalled; the sum is a 32-bit binary
// accumulate per 16-bit word, folded to ones' complement only at the report. A
// byte passes the stage a, b and c registers and the queue to the output. The
// four-entry queue absorbs the second result of a last byte; input stall rises
// only while it holds more than two results, so a stalled output pauses the input.
module udp_header_checksum_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    input  logic        i_last,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_destination_address,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_byte_offset,
    output logic [15:0] o_source_port,
    output logic [15:0] o_destination_port,
    output logic [15:0] o_datagram_length,
    output logic        o_checksum_ok,
    output logic        o_final_res
);

    localparam int unsigned SumW = udpcsum_pkg::SumW;
    localparam int unsigned QAw  = udpcsum_pkg::QAw;

    // pipeline advance: room for two results in the queue
    logic           w_en;
    logic [QAw:0]   r_cnt;

    assign w_en       = (r_cnt <= (QAw+1)'(udpcsum_pkg::QDepth - 2));
    assign o_in_stall = !w_en;

    // ---------------------------------------------------------------
    // stage a: input register, address words pre-added
    // ---------------------------------------------------------------
    logic        r_a_v;
    logic [7:0]  r_a_byte;
    logic        r_a_first;
    logic        r_a_last;
    logic [17:0] r_a_addr;
    logic [17:0] n_a_addr;

    assign n_a_addr = {2'b0, i_source_address[31:16]} + {2'b0, i_source_address[15:0]}
                    + {2'b0, i_destination_address[31:16]}
                    + {2'b0, i_destination_address[15:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in_valid;
        end
        if (w_en && i_in_valid) begin
            r_a_byte  <= i_data_byte;
            r_a_first <= i_first;
            r_a_last  <= i_last;
            r_a_addr  <= n_a_addr;
        end
    end

    // ---------------------------------------------------------------
    // stage b: datagram state update
    // ---------------------------------------------------------------
    logic [15:0]     r_off;
    logic [SumW-1:0] r_sum;
    logic [7:0]      r_pend;
    logic [15:0]     r_sport;
    logic [15:0]     r_dport;
    logic [15:0]     r_len;

    logic [15:0]     b_off;
    logic [SumW-1:0] b_sum;
    logic [7:0]      b_pend;
    logic [15:0]     b_sport;
    logic [15:0]     b_dport;
    logic [15:0]     b_len;

    logic [15:0]     n_off;
    logic [SumW-1:0] n_sum;
    logic [7:0]      n_pend;
    logic [15:0]     n_sport;
    logic [15:0]     n_dport;
    logic [15:0]     n_len;
    logic            w_in_sum;
    logic            w_pay;
    logic            w_rep;

    always_comb begin
        // a first byte starts from cleared state plus the address words
        b_off   = r_a_first ? 16'd0 : r_off;
        b_sum   = r_a_first ? {{(SumW-18){1'b0}}, r_a_addr} : r_sum;
        b_pend  = r_a_first ? 8'd0  : r_pend;
        b_sport = r_a_first ? 16'd0 : r_sport;
        b_dport = r_a_first ? 16'd0 : r_dport;
        b_len   = r_a_first ? 16'd0 : r_len;

        n_sport = b_sport;
        n_dport = b_dport;
        n_len   = b_len;
        n_sum   = b_sum;
        n_pend  = b_pend;

        // header field capture
        unique case (b_off)
            udpcsum_pkg::OffSrcHi: n_sport[15:8] = r_a_byte;
            udpcsum_pkg::OffSrcLo: n_sport[7:0]  = r_a_byte;
            udpcsum_pkg::OffDstHi: n_dport[15:8] = r_a_byte;
            udpcsum_pkg::OffDstLo: n_dport[7:0]  = r_a_byte;
            udpcsum_pkg::OffLenHi: n_len[15:8]   = r_a_byte;
            udpcsum_pkg::OffLenLo: n_len[7:0]    = r_a_byte;
            default: ;
        endcase

        // even byte waits for its partner, odd byte completes a word
        w_in_sum = (b_off >= udpcsum_pkg::OffSumStart) && (b_off < b_len);
        if (w_in_sum) begin
            if (!b_off[0]) begin
                n_pend = r_a_byte;
            end else begin
                n_sum  = b_sum + {{(SumW-16){1'b0}}, b_pend, r_a_byte};
                n_pend = 8'd0;
            end
        end

        w_pay = (b_off >= udpcsum_pkg::OffPayStart) && (b_off < b_len);
        w_rep = r_a_last && (b_off >= udpcsum_pkg::OffRepMin);
        n_off = (b_off == udpcsum_pkg::OffsetMax) ? b_off : b_off + 16'd1;
    end

    logic            r_b_pay_v;
    logic            r_b_rep_v;
    logic [7:0]      r_b_byte;
    logic [15:0]     r_b_off;
    logic [SumW-1:0] r_b_sum;
    logic [7:0]      r_b_pend;
    logic [15:0]     r_b_sport;
    logic [15:0]     r_b_dport;
    logic [15:0]     r_b_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off     <= '0;
            r_sum     <= '0;
            r_pend    <= '0;
            r_sport   <= '0;
            r_dport   <= '0;
            r_len     <= '0;
            r_b_pay_v <= 1'b0;
            r_b_rep_v <= 1'b0;
        end else if (w_en) begin
            r_b_pay_v <= r_a_v && w_pay;
            r_b_rep_v <= r_a_v && w_rep;
            if (r_a_v) begin
                // the datagram end returns all state to its cleared value
                if (r_a_last) begin
                    r_off   <= '0;
                    r_sum   <= '0;
                    r_pend  <= '0;
                    r_sport <= '0;
                    r_dport <= '0;
                    r_len   <= '0;
                end else begin
                    r_off   <= n_off;
                    r_sum   <= n_sum;
                    r_pend  <= n_pend;
                    r_sport <= n_sport;
                    r_dport <= n_dport;
                    r_len   <= n_len;
                end
            end
        end
        if (w_en && r_a_v) begin
            r_b_byte  <= r_a_byte;
            r_b_off   <= b_off;
            r_b_sum   <= n_sum;
            r_b_pend  <= n_pend;
            r_b_sport <= n_sport;
            r_b_dport <= n_dport;
            r_b_len   <= n_len;
        end
    end

    // ---------------------------------------------------------------
    // stage c: binary total of the report sum
    // ---------------------------------------------------------------
    logic [15:0]     w_h_sport;
    logic [15:0]     w_h_dport;
    logic [15:0]     w_h_len;
    logic [SumW-1:0] w_total;

    // header words count only for the bytes that lie below the length field
    always_comb begin
        if (r_b_len > 16'd1)       w_h_sport = r_b_sport;
        else if (r_b_len == 16'd1) w_h_sport = {r_b_sport[15:8], 8'd0};
        else                       w_h_sport = 16'd0;

        if (r_b_len > 16'd3)       w_h_dport = r_b_dport;
        else if (r_b_len == 16'd3) w_h_dport = {r_b_dport[15:8], 8'd0};
        else                       w_h_dport = 16'd0;

        if (r_b_len > 16'd5)       w_h_len = r_b_len;
        else if (r_b_len == 16'd5) w_h_len = {r_b_len[15:8], 8'd0};
        else                       w_h_len = 16'd0;

        w_total = r_b_sum
                + {{(SumW-16){1'b0}}, r_b_pend, 8'd0}
                + {{(SumW-16){1'b0}}, udpcsum_pkg::ProtoUdp}
                + {{(SumW-16){1'b0}}, r_b_len}
                + {{(SumW-16){1'b0}}, w_h_sport}
                + {{(SumW-16){1'b0}}, w_h_dport}
                + {{(SumW-16){1'b0}}, w_h_len};
    end

    logic            r_c_pay_v;
    logic            r_c_rep_v;
    logic [7:0]      r_c_byte;
    logic [15:0]     r_c_off;
    logic [SumW-1:0] r_c_total;
    logic [15:0]     r_c_sport;
    logic [15:0]     r_c_dport;
    logic [15:0]     r_c_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_pay_v <= 1'b0;
            r_c_rep_v <= 1'b0;
        end else if (w_en) begin
            r_c_pay_v <= r_b_pay_v;
            r_c_rep_v <= r_b_rep_v;
        end
        if (w_en) begin
            r_c_byte  <= r_b_byte;
            r_c_off   <= r_b_off;
            r_c_total <= w_total;
            r_c_sport <= r_b_sport;
            r_c_dport <= r_b_dport;
            r_c_len   <= r_b_len;
        end
    end

    // ---------------------------------------------------------------
    // fold with end-around carry and build the results
    // ---------------------------------------------------------------
    logic [16:0]          w_fold1;
    logic [15:0]          w_fold2;
    udpcsum_pkg::t_result w_pay_res;
    udpcsum_pkg::t_result w_rep_res;

    assign w_fold1 = {1'b0, r_c_total[31:16]} + {1'b0, r_c_total[15:0]};
    assign w_fold2 = w_fold1[15:0] + {15'd0, w_fold1[16]};

    always_comb begin
        w_pay_res                  = '0;
        w_pay_res.kind             = udpcsum_pkg::KindPayload;
        w_pay_res.payload_byte     = r_c_byte;
        w_pay_res.byte_offset      = r_c_off;

        w_rep_res                  = '0;
        w_rep_res.kind             = udpcsum_pkg::KindReport;
        w_rep_res.byte_offset      = r_c_off;
        w_rep_res.source_port      = r_c_sport;
        w_rep_res.destination_port = r_c_dport;
        w_rep_res.datagram_length  = r_c_len;
        w_rep_res.checksum_ok      = (w_fold2 == udpcsum_pkg::SumAllOnes);
        w_rep_res.final_res        = 1'b1;
    end

    // ---------------------------------------------------------------
    // result queue, up to two writes and one read per cycle
    // ---------------------------------------------------------------
    udpcsum_pkg::t_result r_q [udpcsum_pkg::QDepth];
    logic [QAw-1:0]       r_wp;
    logic [QAw-1:0]       r_rp;
    logic                 w_push_pay;
    logic                 w_push_rep;
    logic                 w_pop;
    logic [QAw-1:0]       w_rep_wp;
    logic [QAw:0]         w_n_push;

    assign w_push_pay = w_en && r_c_pay_v;
    assign w_push_rep = w_en && r_c_rep_v;
    assign w_pop      = o_out_valid && !i_out_stall;
    assign w_rep_wp   = r_wp + {{(QAw-1){1'b0}}, w_push_pay};
    assign w_n_push   = {{QAw{1'b0}}, w_push_pay} + {{QAw{1'b0}}, w_push_rep};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + w_n_push[QAw-1:0];
            r_rp  <= r_rp + {{(QAw-1){1'b0}}, w_pop};
            r_cnt <= r_cnt + w_n_push - {{QAw{1'b0}}, w_pop};
        end
        if (w_push_pay) begin
            r_q[r_wp] <= w_pay_res;
        end
        if (w_push_rep) begin
            r_q[w_rep_wp] <= w_rep_res;
        end
    end

    // output port from the queue head
    udpcsum_pkg::t_result w_head;

    assign w_head             = r_q[r_rp];
    assign o_out_valid        = (r_cnt != '0);
    assign o_kind             = w_head.kind;
    assign o_payload_byte     = w_head.payload_byte;
    assign o_byte_offset      = w_head.byte_offset;
    assign o_source_port      = w_head.source_port;
    assign o_destination_port = w_head.destination_port;
    assign o_datagram_length  = w_head.datagram_length;
    assign o_checksum_ok      = w_head.checksum_ok;
    assign o_final_res        = w_head.final_res;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAw+1)'(udpcsum_pkg::QDepth))
        else $error("result queue overfilled");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > (QAw+1)'(udpcsum_pkg::QDepth - 2)) |-> o_in_stall)
        else $error("input taken without room for two results");

    a_payload_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == udpcsum_pkg::KindPayload))
            |-> (o_byte_offset >= udpcsum_pkg::OffPayStart) && !o_final_res)
        else $error("payload result inside the udp header");

    a_report_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == udpcsum_pkg::KindReport))
            |-> (o_byte_offset >= udpcsum_pkg::OffRepMin) && o_final_res)
        else $error("report for a datagram shorter than its header");

endmodule
